### hdl/sgcp_pkg.sv
// sgcp_pkg: types, codes and lookup tables of the serial gamepad command parser
// depends on nothing; used by every module of the block
package sgcp_pkg;

	localparam int CMD_MAX_DEF = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int TOK_N       = 26;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_MID = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_MAX = 3'd3;

	localparam logic [7:0]  TIMEOUT_RST  = 8'd20;
	localparam logic [15:0] AXIS_MIN_RST = 16'd0;
	localparam logic [15:0] AXIS_MID_RST = 16'd32767;
	localparam logic [15:0] AXIS_MAX_RST = 16'd65535;

	// event codes
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_LEGACY  = 3'd1;
	localparam logic [2:0] EV_PRESS   = 3'd2;
	localparam logic [2:0] EV_RELEASE = 3'd3;
	localparam logic [2:0] EV_CLEAR   = 3'd4;

	// characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = ":";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_P     = "P";
	localparam logic [7:0] CH_LP    = "p";
	localparam logic [7:0] CH_R     = "R";
	localparam logic [7:0] CH_LR    = "r";
	localparam logic [7:0] CH_C     = "C";
	localparam logic [39:0] CLEAR_STR = "CLEAR";

	typedef enum logic [1:0] {TGT_BTN, TGT_DPAD, TGT_LS, TGT_RS} tgt_t;
	typedef enum logic [1:0] {OP_NOP, OP_SET, OP_RESET, OP_CLEAR} op_t;

	localparam logic [3:0] DIR_UP    = 4'd0;
	localparam logic [3:0] DIR_DOWN  = 4'd1;
	localparam logic [3:0] DIR_LEFT  = 4'd2;
	localparam logic [3:0] DIR_RIGHT = 4'd3;

	// one classified command handed from front to back
	typedef struct packed {
		op_t        op;
		tgt_t       tgt;
		logic [3:0] bitno;
		logic [2:0] ev;
	} action_t;

	// token entry: name left aligned, zero padded
	typedef struct packed {
		logic [63:0] name;
		logic [3:0]  len;
		tgt_t        tgt;
		logic [3:0]  bitno;
	} tok_t;

	localparam tok_t TOK_TAB [TOK_N] = '{
		'{{"A", 56'h0}, 4'd1, TGT_BTN, 4'd1},
		'{{"B", 56'h0}, 4'd1, TGT_BTN, 4'd0},
		'{{"X", 56'h0}, 4'd1, TGT_BTN, 4'd3},
		'{{"Y", 56'h0}, 4'd1, TGT_BTN, 4'd2},
		'{{"L", 56'h0}, 4'd1, TGT_BTN, 4'd4},
		'{{"R", 56'h0}, 4'd1, TGT_BTN, 4'd5},
		'{{"ZL", 48'h0}, 4'd2, TGT_BTN, 4'd6},
		'{{"ZR", 48'h0}, 4'd2, TGT_BTN, 4'd7},
		'{{"MINUS", 24'h0}, 4'd5, TGT_BTN, 4'd8},
		'{{"PLUS", 32'h0}, 4'd4, TGT_BTN, 4'd9},
		'{{"HOME", 32'h0}, 4'd4, TGT_BTN, 4'd12},
		'{{"CAPTURE", 8'h0}, 4'd7, TGT_BTN, 4'd13},
		'{{"L3", 48'h0}, 4'd2, TGT_BTN, 4'd10},
		'{{"R3", 48'h0}, 4'd2, TGT_BTN, 4'd11},
		'{{"UP", 48'h0}, 4'd2, TGT_DPAD, DIR_UP},
		'{{"DOWN", 32'h0}, 4'd4, TGT_DPAD, DIR_DOWN},
		'{{"LEFT", 32'h0}, 4'd4, TGT_DPAD, DIR_LEFT},
		'{{"RIGHT", 24'h0}, 4'd5, TGT_DPAD, DIR_RIGHT},
		'{{"LS_UP", 24'h0}, 4'd5, TGT_LS, DIR_UP},
		'{{"LS_DOWN", 8'h0}, 4'd7, TGT_LS, DIR_DOWN},
		'{{"LS_LEFT", 8'h0}, 4'd7, TGT_LS, DIR_LEFT},
		'{{"LS_", "RIGHT"}, 4'd8, TGT_LS, DIR_RIGHT},
		'{{"RS_UP", 24'h0}, 4'd5, TGT_RS, DIR_UP},
		'{{"RS_DOWN", 8'h0}, 4'd7, TGT_RS, DIR_DOWN},
		'{{"RS_LEFT", 8'h0}, 4'd7, TGT_RS, DIR_LEFT},
		'{{"RS_", "RIGHT"}, 4'd8, TGT_RS, DIR_RIGHT}
	};

	// single byte shortcut lookup
	typedef struct packed {
		logic       hit;
		logic       clr;
		tgt_t       tgt;
		logic [3:0] bitno;
	} leg_t;

	function automatic leg_t legacy_lookup(input logic [7:0] c);
		leg_t l;
		l = '{hit: 1'b1, clr: 1'b0, tgt: TGT_BTN, bitno: 4'd0};
		unique case (c)
			"0": l.clr = 1'b1;
			"A": l.bitno = 4'd1;
			"B": l.bitno = 4'd0;
			"X": l.bitno = 4'd3;
			"Y": l.bitno = 4'd2;
			"L": l.bitno = 4'd4;
			"R": l.bitno = 4'd5;
			"l": l.bitno = 4'd6;
			"r": l.bitno = 4'd7;
			"+": l.bitno = 4'd9;
			"-": l.bitno = 4'd8;
			"H": l.bitno = 4'd12;
			"C": l.bitno = 4'd13;
			"1": l.bitno = 4'd10;
			"2": l.bitno = 4'd11;
			"U": begin l.tgt = TGT_DPAD; l.bitno = DIR_UP; end
			"D": begin l.tgt = TGT_DPAD; l.bitno = DIR_DOWN; end
			"<": begin l.tgt = TGT_DPAD; l.bitno = DIR_LEFT; end
			">": begin l.tgt = TGT_DPAD; l.bitno = DIR_RIGHT; end
			"w": begin l.tgt = TGT_LS; l.bitno = DIR_UP; end
			"s": begin l.tgt = TGT_LS; l.bitno = DIR_DOWN; end
			"a": begin l.tgt = TGT_LS; l.bitno = DIR_LEFT; end
			"d": begin l.tgt = TGT_LS; l.bitno = DIR_RIGHT; end
			"i": begin l.tgt = TGT_RS; l.bitno = DIR_UP; end
			"k": begin l.tgt = TGT_RS; l.bitno = DIR_DOWN; end
			"j": begin l.tgt = TGT_RS; l.bitno = DIR_LEFT; end
			"m": begin l.tgt = TGT_RS; l.bitno = DIR_RIGHT; end
			default: l.hit = 1'b0;
		endcase
		return l;
	endfunction

	function automatic action_t legacy_act(input leg_t l);
		action_t a;
		a.op    = l.clr ? OP_CLEAR : OP_SET;
		a.tgt   = l.tgt;
		a.bitno = l.bitno;
		a.ev    = EV_LEGACY;
		return a;
	endfunction

endpackage

### hdl/sgcp_front.sv
// sgcp_front: per-byte command tracker; classifies each beat into one action
// depends on sgcp_pkg
module sgcp_front #(
	parameter int CMD_MAX = sgcp_pkg::CMD_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                mode,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          timeout_ticks,
	output sgcp_pkg::action_t   act
);
	import sgcp_pkg::*;

	localparam int LEN_W = $clog2(CMD_MAX + 1);

	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0]       first_q, first_d;
	logic             sec_colon_q, sec_colon_d;
	logic             colon_q, colon_d;
	logic             clr_ok_q, clr_ok_d;
	logic [TOK_N-1:0] match_q, match_d;
	logic             run_q, run_d;
	logic [7:0]       cnt_q, cnt_d;

	logic [LEN_W-1:0] tpos;
	logic [7:0]       cnt_inc;
	logic             is_c, is_clear, flush;
	leg_t             leg_first, leg_byte;
	logic             tok_hit;
	tgt_t             tok_tgt;
	logic [3:0]       tok_bit;
	logic [TOK_N-1:0] match_app;
	action_t          cmd_act;

	assign tpos      = LEN_W'(len_q - LEN_W'(2));
	assign leg_first = legacy_lookup(first_q);
	assign leg_byte  = legacy_lookup(rx_byte);
	assign is_c      = (len_q == LEN_W'(1)) && (first_q == CH_C);
	assign is_clear  = (len_q == LEN_W'(5)) && clr_ok_q;
	assign cnt_inc   = (run_q && cnt_q != 8'hFF) ? 8'(cnt_q + 8'd1) : cnt_q;
	assign flush     = (len_q != '0) && run_q && !colon_q && !is_c && !is_clear
		&& (cnt_inc > timeout_ticks);

	// exact token match at end of line, and match update on append
	always_comb begin
		tok_hit = 1'b0;
		tok_tgt = TGT_BTN;
		tok_bit = '0;
		for (int i = 0; i < TOK_N; i++) begin
			match_app[i] = match_q[i] && (tpos < LEN_W'(TOK_TAB[i].len))
				&& (TOK_TAB[i].name[8*(7 - int'(tpos[2:0])) +: 8] == rx_byte);
			if (match_q[i] && tpos == LEN_W'(TOK_TAB[i].len)) begin
				tok_hit = 1'b1;
				tok_tgt = TOK_TAB[i].tgt;
				tok_bit = TOK_TAB[i].bitno;
			end
		end
	end

	// line terminator: decode the buffered command
	always_comb begin
		cmd_act = '{op: OP_NOP, tgt: TGT_BTN, bitno: 4'd0, ev: EV_NONE};
		if (is_c || is_clear) begin
			cmd_act.op = OP_CLEAR;
			cmd_act.ev = EV_CLEAR;
		end else if (len_q >= LEN_W'(3) && sec_colon_q) begin
			if (first_q == CH_P || first_q == CH_LP) begin
				cmd_act = '{op: tok_hit ? OP_SET : OP_NOP, tgt: tok_tgt, bitno: tok_bit,
					ev: EV_PRESS};
			end else if (first_q == CH_R || first_q == CH_LR) begin
				cmd_act = '{op: tok_hit ? OP_RESET : OP_NOP, tgt: tok_tgt,
					bitno: tok_bit, ev: EV_RELEASE};
			end
		end else if (len_q == LEN_W'(1) && leg_first.hit) begin
			cmd_act = legacy_act(leg_first);
		end
	end

	// next state and action of this beat
	always_comb begin
		len_d       = len_q;
		first_d     = first_q;
		sec_colon_d = sec_colon_q;
		colon_d     = colon_q;
		clr_ok_d    = clr_ok_q;
		match_d     = match_q;
		run_d       = run_q;
		cnt_d       = cnt_q;
		act         = '{op: OP_NOP, tgt: TGT_BTN, bitno: 4'd0, ev: EV_NONE};
		if (mode) begin
			cnt_d = cnt_inc;
			if (flush) begin
				if (len_q == LEN_W'(1) && leg_first.hit) act = legacy_act(leg_first);
				len_d = '0;
				run_d = 1'b0;
				cnt_d = '0;
			end
		end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
			if (len_q != '0) begin
				act   = cmd_act;
				len_d = '0;
				run_d = 1'b0;
				cnt_d = '0;
			end
		end else if (rx_byte == CH_SPACE) begin
			len_d = len_q;
		end else if (len_q == '0
			&& (rx_byte == CH_P || rx_byte == CH_R || rx_byte == CH_C)) begin
			first_d  = rx_byte;
			len_d    = LEN_W'(1);
			run_d    = 1'b1;
			cnt_d    = '0;
			colon_d  = 1'b0;
			clr_ok_d = (rx_byte == CH_C);
			match_d  = '1;
		end else if (len_q == '0 && leg_byte.hit) begin
			act = legacy_act(leg_byte);
		end else if (len_q < LEN_W'(CMD_MAX)) begin
			len_d   = LEN_W'(len_q + LEN_W'(1));
			colon_d = colon_q || (rx_byte == CH_COLON);
			if (len_q == '0) begin
				first_d  = rx_byte;
				clr_ok_d = 1'b0;
				match_d  = '1;
			end else begin
				clr_ok_d = clr_ok_q && (len_q < LEN_W'(5))
					&& (CLEAR_STR[8*(4 - int'(len_q[2:0])) +: 8] == rx_byte);
				if (len_q == LEN_W'(1)) sec_colon_d = (rx_byte == CH_COLON);
				else match_d = match_app;
			end
		end else begin
			len_d = '0;
			run_d = 1'b0;
			cnt_d = '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (accept) begin
			len_q <= len_d;
			run_q <= run_d;
			cnt_q <= cnt_d;
		end
	end

	// buffer summary
	always_ff @(posedge clk) begin
		if (accept) begin
			first_q     <= first_d;
			sec_colon_q <= sec_colon_d;
			colon_q     <= colon_d;
			clr_ok_q    <= clr_ok_d;
			match_q     <= match_d;
		end
	end

endmodule

### hdl/sgcp_queue.sv
// sgcp_queue: two-entry action queue between front and back
// depends on sgcp_pkg
module sgcp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sgcp_pkg::action_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output sgcp_pkg::action_t pop_data
);
	import sgcp_pkg::*;

	action_t    ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = ent_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_data;
	end

endmodule

### hdl/sgcp_back.sv
// sgcp_back: applies actions to the held state and presents each result beat
// depends on sgcp_pkg
module sgcp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              avail,
	input  sgcp_pkg::action_t act,
	output logic              take,
	input  logic [15:0]       axis_min,
	input  logic [15:0]       axis_mid,
	input  logic [15:0]       axis_max,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [13:0]       buttons,
	output logic [3:0]        dpad,
	output logic [15:0]       left_x,
	output logic [15:0]       left_y,
	output logic [15:0]       right_x,
	output logic [15:0]       right_y,
	output logic [2:0]        event_res
);
	import sgcp_pkg::*;

	logic [13:0] btn_q, btn_d;
	logic [3:0]  dpad_q, dpad_d, ls_q, ls_d, rs_q, rs_d;
	logic [2:0]  ev_q;
	logic        valid_q;
	logic [15:0] bmask;

	function automatic logic [15:0] axis_val(input logic lo, input logic hi,
		input logic [15:0] vmin, input logic [15:0] vmid, input logic [15:0] vmax);
		if (lo == hi) return vmid;
		return lo ? vmin : vmax;
	endfunction

	assign take  = avail && (!valid_q || !out_stall);
	assign bmask = 16'(16'd1 << act.bitno);

	// apply one action
	always_comb begin
		btn_d  = btn_q;
		dpad_d = dpad_q;
		ls_d   = ls_q;
		rs_d   = rs_q;
		unique case (act.op)
			OP_CLEAR: begin
				btn_d  = '0;
				dpad_d = '0;
				ls_d   = '0;
				rs_d   = '0;
			end
			OP_SET, OP_RESET: begin
				unique case (act.tgt)
					TGT_BTN: btn_d = (act.op == OP_SET) ? (btn_q | bmask[13:0])
						: (btn_q & ~bmask[13:0]);
					TGT_DPAD: dpad_d = (act.op == OP_SET) ? (dpad_q | bmask[3:0])
						: (dpad_q & ~bmask[3:0]);
					TGT_LS: ls_d = (act.op == OP_SET) ? (ls_q | bmask[3:0])
						: (ls_q & ~bmask[3:0]);
					TGT_RS: rs_d = (act.op == OP_SET) ? (rs_q | bmask[3:0])
						: (rs_q & ~bmask[3:0]);
					default: btn_d = btn_q;
				endcase
			end
			default: btn_d = btn_q;
		endcase
	end

	// held state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_q   <= '0;
			dpad_q  <= '0;
			ls_q    <= '0;
			rs_q    <= '0;
			ev_q    <= EV_NONE;
			valid_q <= 1'b0;
		end else if (take) begin
			btn_q   <= btn_d;
			dpad_q  <= dpad_d;
			ls_q    <= ls_d;
			rs_q    <= rs_d;
			ev_q    <= act.ev;
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign buttons   = btn_q;
	assign dpad      = dpad_q;
	assign event_res = ev_q;
	assign left_x  = axis_val(ls_q[DIR_LEFT[1:0]], ls_q[DIR_RIGHT[1:0]], axis_min, axis_mid,
		axis_max);
	assign left_y  = axis_val(ls_q[DIR_UP[1:0]], ls_q[DIR_DOWN[1:0]], axis_min, axis_mid,
		axis_max);
	assign right_x = axis_val(rs_q[DIR_LEFT[1:0]], rs_q[DIR_RIGHT[1:0]], axis_min, axis_mid,
		axis_max);
	assign right_y = axis_val(rs_q[DIR_UP[1:0]], rs_q[DIR_DOWN[1:0]], axis_min, axis_mid,
		axis_max);

endmodule

### hdl/serial_gamepad_command_parser.sv
// serial_gamepad_command_parser: top level with configuration registers
// depends on sgcp_pkg, sgcp_front, sgcp_queue, sgcp_back
//
// Usage:
// Input beats carry mode (0 = received byte, 1 = millisecond tick) and
// rx_byte; a beat is taken when in_valid is high and in_stall is low.
// Every input beat yields exactly one result beat with the latched buttons,
// dpad bits, four stick axes and an event code, taken when out_valid is
// high and out_stall is low.
// The front tracks the command line byte by byte (token prefix matching, no
// character store) and classifies each beat into one action; a two-entry
// queue feeds the back, which updates the held state.
// A result beat's action is registered in a queue entry and then in the back's result register.
// Throughput: one beat per cycle while the queue has room; the front updates on each taken beat.
// When the receiver stalls, the back holds its result, the queue fills and
// in_stall rises once both entries are occupied.
// Reset clears all held state, the line tracker and the queue; registers
// return to timeout 20 and axes 0 / 32767 / 65535. The configuration port
// is always ready; the user must write it only while the block is idle (not enforced).
module serial_gamepad_command_parser #(
	parameter int CMD_MAX = sgcp_pkg::CMD_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [13:0]                     buttons,
	output logic [3:0]                      dpad,
	output logic [15:0]                     left_x,
	output logic [15:0]                     left_y,
	output logic [15:0]                     right_x,
	output logic [15:0]                     right_y,
	output logic [2:0]                      event_res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sgcp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sgcp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sgcp_pkg::*;

	logic [7:0]  timeout_q;
	logic [15:0] axis_min_q, axis_mid_q, axis_max_q;
	logic        accept, q_full, q_avail, take;
	action_t     f_act, q_act;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			axis_min_q <= AXIS_MIN_RST;
			axis_mid_q <= AXIS_MID_RST;
			axis_max_q <= AXIS_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIMEOUT:  timeout_q  <= cfg_data[7:0];
				REG_AXIS_MIN: axis_min_q <= cfg_data;
				REG_AXIS_MID: axis_mid_q <= cfg_data;
				REG_AXIS_MAX: axis_max_q <= cfg_data;
				default: timeout_q <= timeout_q;
			endcase
		end
	end

	sgcp_front #(.CMD_MAX(CMD_MAX)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.mode          (mode),
		.rx_byte       (rx_byte),
		.timeout_ticks (timeout_q),
		.act           (f_act)
	);

	sgcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (f_act),
		.full      (q_full),
		.pop       (take),
		.not_empty (q_avail),
		.pop_data  (q_act)
	);

	sgcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (q_avail),
		.act       (q_act),
		.take      (take),
		.axis_min  (axis_min_q),
		.axis_mid  (axis_mid_q),
		.axis_max  (axis_max_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.buttons   (buttons),
		.dpad      (dpad),
		.left_x    (left_x),
		.left_y    (left_y),
		.right_x   (right_x),
		.right_y   (right_y),
		.event_res (event_res)
	);

endmodule

### hdl/sgcp_checker.sv
// sgcp_checker: port-level assertions for serial_gamepad_command_parser
// depends on sgcp_pkg; bound to the top level below
module sgcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [13:0] buttons,
	input logic [3:0]  dpad,
	input logic [15:0] left_x,
	input logic [2:0]  event_res
);
	import sgcp_pkg::*;

	// stalled result beat stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped under stall");

	// stalled result keeps its buttons, event code and left_x
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(buttons) && $stable(event_res)
			&& $stable(left_x))
		else $error("result payload changed under stall");

	// event code within range
	a_ev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_res <= EV_CLEAR))
		else $error("bad event code");

	// clear command leaves no buttons or dpad bits held
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_CLEAR |-> buttons == '0 && dpad == '0)
		else $error("clear left inputs held");

endmodule

bind serial_gamepad_command_parser sgcp_checker u_sgcp_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for serial_gamepad_command_parser
// depends on sgcp_pkg and the parser RTL; predicts every result beat in-line
module testbench;
	import sgcp_pkg::*;

	localparam int CMDMAX = CMD_MAX_DEF;
	localparam int WDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [13:0] buttons;
	logic [3:0] dpad;
	logic [15:0] left_x, left_y, right_x, right_y;
	logic [2:0] event_res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	serial_gamepad_command_parser dut (.*);

	always #6 clk = ~clk;

	// one expected result beat
	typedef struct {
		logic [13:0] btn;
		logic [3:0]  dp;
		logic [15:0] lx, ly, rx, ry;
		logic [2:0]  ev;
	} pad_state_t;

	pad_state_t pad_fifo[$];
	int fail_cnt = 0;
	int idle_cycles = 0;

	// predictor state
	logic [7:0]  line_buf [CMDMAX];
	int          line_len;
	logic        timer_on;
	logic [7:0]  timer_cnt;
	logic [13:0] p_btn;
	logic [3:0]  p_dpad, p_ls, p_rs;
	logic [7:0]  r_timeout;
	logic [15:0] r_min, r_mid, r_max;

	// token names with their target and bit
	string tok_name [26] = '{"A","B","X","Y","L","R","ZL","ZR","MINUS","PLUS","HOME",
		"CAPTURE","L3","R3","UP","DOWN","LEFT","RIGHT","LS_UP","LS_DOWN","LS_LEFT",
		{"LS_", "RIGHT"},"RS_UP","RS_DOWN","RS_LEFT",{"RS_", "RIGHT"}};
	tgt_t tok_tgt [26] = '{TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,
		TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_DPAD,TGT_DPAD,
		TGT_DPAD,TGT_DPAD,TGT_LS,TGT_LS,TGT_LS,TGT_LS,TGT_RS,TGT_RS,TGT_RS,TGT_RS};
	int tok_bit [26] = '{1,0,3,2,4,5,6,7,8,9,12,13,10,11,0,1,2,3,0,1,2,3,0,1,2,3};
	string shortcut_chars = "ABXYLRlr+-HC12UD<>wsadikjm";
	tgt_t sc_tgt [26] = '{TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,
		TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_BTN,TGT_DPAD,TGT_DPAD,
		TGT_DPAD,TGT_DPAD,TGT_LS,TGT_LS,TGT_LS,TGT_LS,TGT_RS,TGT_RS,TGT_RS,TGT_RS};
	int sc_bit [26] = '{1,0,3,2,4,5,6,7,9,8,12,13,10,11,0,1,2,3,0,1,2,3,0,1,2,3};

	function automatic void clear_held();
		p_btn = '0; p_dpad = '0; p_ls = '0; p_rs = '0;
		line_len = 0; timer_on = 1'b0; timer_cnt = '0;
	endfunction

	function automatic void set_bit(input tgt_t t, input int b, input logic v);
		case (t)
			TGT_BTN:  p_btn[b] = v;
			TGT_DPAD: p_dpad[b] = v;
			TGT_LS:   p_ls[b] = v;
			default:  p_rs[b] = v;
		endcase
	endfunction

	function automatic logic shortcut(input logic [7:0] c);
		if (c == CH_ZERO) begin
			clear_held();
			return 1'b1;
		end
		for (int i = 0; i < 26; i++)
			if (shortcut_chars[i] == c) begin
				set_bit(sc_tgt[i], sc_bit[i], 1'b1);
				return 1'b1;
			end
		return 1'b0;
	endfunction

	function automatic logic line_is(input int off, input string s);
		if (line_len - off != s.len()) return 1'b0;
		for (int i = 0; i < s.len(); i++)
			if (line_buf[off + i] != s[i]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic line_has_colon();
		for (int i = 0; i < line_len; i++)
			if (line_buf[i] == CH_COLON) return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [2:0] run_line();
		logic pr;
		if (line_is(0, "C") || line_is(0, "CLEAR")) begin
			clear_held();
			return EV_CLEAR;
		end
		if (line_len >= 3 && line_buf[1] == CH_COLON) begin
			if (line_buf[0] == CH_P || line_buf[0] == CH_LP) pr = 1'b1;
			else if (line_buf[0] == CH_R || line_buf[0] == CH_LR) pr = 1'b0;
			else return EV_NONE;
			for (int i = 0; i < 26; i++)
				if (line_is(2, tok_name[i])) begin
					set_bit(tok_tgt[i], tok_bit[i], pr);
					break;
				end
			return pr ? EV_PRESS : EV_RELEASE;
		end
		if (line_len == 1 && shortcut(line_buf[0])) return EV_LEGACY;
		return EV_NONE;
	endfunction

	function automatic logic [15:0] axis_of(input logic lo, input logic hi);
		if (lo == hi) return r_mid;
		return lo ? r_min : r_max;
	endfunction

	// advance the predicted pad state by one beat and queue the result
	task automatic predict_pad(input logic m, input logic [7:0] c);
		pad_state_t e;
		logic [2:0] ev;
		ev = EV_NONE;
		if (m) begin
			if (timer_on && timer_cnt != 8'hFF) timer_cnt++;
			if (line_len != 0 && timer_on && !line_has_colon() && !line_is(0, "C") &&
				!line_is(0, "CLEAR") && timer_cnt > r_timeout) begin
				if (line_len == 1 && shortcut(line_buf[0])) ev = EV_LEGACY;
				line_len = 0; timer_on = 1'b0; timer_cnt = '0;
			end
		end else if (c == CH_LF || c == CH_CR) begin
			if (line_len != 0) begin
				ev = run_line();
				line_len = 0; timer_on = 1'b0; timer_cnt = '0;
			end
		end else if (c == CH_SPACE) begin
		end else if (line_len == 0 && (c == CH_P || c == CH_R || c == CH_C)) begin
			line_buf[0] = c; line_len = 1; timer_on = 1'b1; timer_cnt = '0;
		end else if (line_len == 0 && shortcut(c)) begin
			ev = EV_LEGACY;
		end else if (line_len < CMDMAX) begin
			line_buf[line_len] = c; line_len++;
		end else begin
			line_len = 0; timer_on = 1'b0; timer_cnt = '0;
		end
		e.btn = p_btn; e.dp = p_dpad; e.ev = ev;
		e.lx = axis_of(p_ls[DIR_LEFT[1:0]], p_ls[DIR_RIGHT[1:0]]);
		e.ly = axis_of(p_ls[DIR_UP[1:0]], p_ls[DIR_DOWN[1:0]]);
		e.rx = axis_of(p_rs[DIR_LEFT[1:0]], p_rs[DIR_RIGHT[1:0]]);
		e.ry = axis_of(p_rs[DIR_UP[1:0]], p_rs[DIR_DOWN[1:0]]);
		pad_fifo = {pad_fifo, e};
	endtask

	// result checker and watchdog
	int rx_pat = 0;
	always @(posedge clk) begin
		pad_state_t e;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WDOG_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (pad_fifo.size() == 0) begin
					$error("result beat with nothing expected");
					fail_cnt++;
				end else begin
					e = pad_fifo.pop_front();
					if (buttons !== e.btn) begin
						$error("buttons exp %h got %h", e.btn, buttons); fail_cnt++;
					end
					if (dpad !== e.dp) begin
						$error("dpad exp %h got %h", e.dp, dpad); fail_cnt++;
					end
					if (left_x !== e.lx) begin
						$error("left_x exp %h got %h", e.lx, left_x); fail_cnt++;
					end
					if (left_y !== e.ly) begin
						$error("left_y exp %h got %h", e.ly, left_y); fail_cnt++;
					end
					if (right_x !== e.rx) begin
						$error("right_x exp %h got %h", e.rx, right_x); fail_cnt++;
					end
					if (right_y !== e.ry) begin
						$error("right_y exp %h got %h", e.ry, right_y); fail_cnt++;
					end
					if (event_res !== e.ev) begin
						$error("event_res exp %0d got %0d", e.ev, event_res); fail_cnt++;
					end
				end
			end
			// receiver stall pattern: phases of free flow, light and heavy stalling
			rx_pat <= rx_pat + 1;
			case ((rx_pat / 300) % 3)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 2) != 0);
			endcase
		end
	end

	// drive one beat and wait until it is taken
	int burst_left = 0;
	task automatic send_beat(input logic m, input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		mode <= m;
		rx_byte <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_pad(m, c);
		burst_left--;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pad_fifo.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TIMEOUT:  r_timeout = v[7:0];
			REG_AXIS_MIN: r_min = v;
			REG_AXIS_MID: r_mid = v;
			default:      r_max = v;
		endcase
	endtask

	// directed table: mode, byte, expected event (or -1 when only the predictor checks)
	typedef struct { logic m; logic [7:0] c; int ev; } dir_row_t;
	dir_row_t dir_tab [] = '{
		'{1'b1, 8'h00, EV_NONE}, '{1'b0, "A", EV_LEGACY}, '{1'b0, "m", EV_LEGACY},
		'{1'b0, "0", EV_LEGACY}, '{1'b0, "P", EV_NONE}, '{1'b0, ":", EV_NONE},
		'{1'b0, "Z", EV_NONE}, '{1'b0, "L", EV_NONE}, '{1'b0, CH_CR, EV_PRESS},
		'{1'b0, "r", -1}, '{1'b0, ":", EV_NONE}, '{1'b0, "Q", EV_NONE},
		'{1'b0, CH_LF, EV_NONE}, '{1'b0, "x", EV_NONE}, '{1'b0, ":", EV_NONE},
		'{1'b0, "A", EV_NONE}, '{1'b0, CH_LF, EV_NONE}, '{1'b0, "C", EV_NONE},
		'{1'b0, CH_SPACE, EV_NONE}, '{1'b0, CH_CR, EV_CLEAR}, '{1'b0, 8'hFF, -1},
		'{1'b0, 8'h00, -1}, '{1'b0, CH_LF, EV_NONE}, '{1'b1, 8'hFF, EV_NONE}
	};

	initial begin
		string s;
		int k;
		logic [15:0] axv;
		r_timeout = TIMEOUT_RST; r_min = AXIS_MIN_RST; r_mid = AXIS_MID_RST;
		r_max = AXIS_MAX_RST;
		clear_held();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset register values
		foreach (dir_tab[i]) begin
			send_beat(dir_tab[i].m, dir_tab[i].c);
			if (dir_tab[i].ev >= 0 && pad_fifo[$].ev != dir_tab[i].ev[2:0]) begin
				$error("event_res exp %0d got %0d (table)", dir_tab[i].ev, pad_fifo[$].ev);
				fail_cnt++;
			end
		end
		// overflow of an untimed buffer, then timeout flush of a partial command and a lone 'R'
		for (int i = 0; i < CMDMAX + 1; i++) send_beat(1'b0, "q");
		send_beat(1'b0, "C"); send_beat(1'b0, "x");
		for (int i = 0; i < 22; i++) send_beat(1'b1, 8'h00);
		send_beat(1'b0, "R");
		for (int i = 0; i < 22; i++) send_beat(1'b1, 8'h00);
		drain();

		// phases of register settings, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_reg(REG_TIMEOUT, 16'd0);
				1: write_reg(REG_TIMEOUT, 16'd255);
				2: write_reg(REG_TIMEOUT, 16'd1);
				default: write_reg(REG_TIMEOUT, 16'($urandom_range(0, 12)));
			endcase
			for (int r = 1; r <= 3; r++) begin
				axv = (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0000 : 16'($urandom);
				write_reg(r[CFG_IDX_W-1:0], axv);
			end
			for (int n = 0; n < 200; n++) begin
				k = $urandom_range(0, 99);
				if (k < 45) begin
					s = ($urandom_range(0, 1) != 0) ? "P:" : "R:";
					if ($urandom_range(0, 7) == 0) s = ($urandom_range(0, 1) != 0) ? "p:" : "r:";
					s = {s, tok_name[$urandom_range(0, 25)]};
					if ($urandom_range(0, 9) == 0) s = {s, "Z"};
					if ($urandom_range(0, 5) == 0) s = {s.substr(0, 1), " ", s.substr(2, s.len() - 1)};
					send_text(s);
					send_beat(1'b0, ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
					n += s.len();
				end else if (k < 60) begin
					send_beat(1'b0, shortcut_chars[$urandom_range(0, 25)]);
				end else if (k < 72) begin
					send_beat(1'b1, 8'($urandom));
				end else if (k < 78) begin
					// partial command left to time out
					send_beat(1'b0, ($urandom_range(0, 1) != 0) ? CH_P : CH_R);
					if ($urandom_range(0, 1) != 0) send_beat(1'b0, "Q");
					repeat ($urandom_range(0, 14)) send_beat(1'b1, 8'h00);
				end else if (k < 82) begin
					send_text(($urandom_range(0, 1) != 0) ? "CLEAR" : "C");
					send_beat(1'b0, CH_LF);
				end else if (k < 84) begin
					send_beat(1'b0, CH_ZERO);
				end else begin
					send_beat(1'b0, 8'($urandom));
				end
			end
			// sender holds off until everything is back
			drain();
		end
		// return the timeout to its reset value; the axis registers keep their last values
		write_reg(REG_TIMEOUT, 16'd20);
		send_text("P:LS_LEFT\n");
		drain();
		if (fail_cnt == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

### files.f
hdl/sgcp_pkg.sv
hdl/sgcp_front.sv
hdl/sgcp_queue.sv
hdl/sgcp_back.sv
hdl/serial_gamepad_command_parser.sv
hdl/sgcp_checker.sv
tb/sv/testbench.sv
